FILE: rtl/core/ogi_pkg.sv
// Shared types, constants and helpers for the occupancy grid inflate unit.
// Used by ogi_mem, ogi_sweep and occupancy_grid_inflate_unit; no dependencies.
package ogi_pkg;

   localparam int unsigned COORD_W  = 8;
   localparam int unsigned ADDR_W   = 2 * COORD_W;
   localparam int unsigned SIZE_W   = 9;
   localparam int unsigned RADIUS_W = 4;
   localparam int unsigned DIST_W   = 5;
   localparam int unsigned SCR_W    = 3;

   localparam logic [SIZE_W-1:0] MAX_SIZE = 9'd256;
   localparam logic [DIST_W-1:0] DIST_SAT = 5'd31;

   localparam logic signed [7:0] OCC_LEVEL     = 8'sd90;
   localparam logic signed [7:0] CAUTION_LEVEL = 8'sd50;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   localparam logic [1:0] CODE_FREE     = 2'd0;
   localparam logic [1:0] CODE_CAUTION  = 2'd1;
   localparam logic [1:0] CODE_OCCUPIED = 2'd2;
   localparam logic [1:0] CODE_UNKNOWN  = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              raw_we;
      logic [7:0]        raw_wdata;
      logic              scr_we;
      logic [SCR_W-1:0]  scr_wdata;
      logic              res_we;
      logic [1:0]        res_wdata;
   } mem_req_type;

   function automatic logic [7:0] code_value(input logic [1:0] code);
      logic [7:0] v;
      case (code)
         CODE_FREE:     v = 8'd0;
         CODE_CAUTION:  v = 8'd50;
         CODE_OCCUPIED: v = 8'd100;
         default:       v = 8'hFF;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/ogi_mem.sv
// Grid storage: raw values, sweep scratch bits and result classes.
// Depends on ogi_pkg for the request structure and widths.
module ogi_mem (
   input  logic                          clock,
   input  ogi_pkg::mem_req_type          mem_req,
   output logic [7:0]                    raw_rdata,
   output logic [ogi_pkg::SCR_W-1:0]     scr_rdata,
   output logic [1:0]                    res_rdata
);

   localparam int unsigned DEPTH = 2 ** ogi_pkg::ADDR_W;

   logic [7:0]                raw_mem [DEPTH];
   logic [ogi_pkg::SCR_W-1:0] scr_mem [DEPTH];
   logic [1:0]                res_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.raw_we) begin
         raw_mem[mem_req.addr] <= mem_req.raw_wdata;
      end
      if (mem_req.scr_we) begin
         scr_mem[mem_req.addr] <= mem_req.scr_wdata;
      end
      if (mem_req.res_we) begin
         res_mem[mem_req.addr] <= mem_req.res_wdata;
      end
      raw_rdata <= raw_mem[mem_req.addr];
      scr_rdata <= scr_mem[mem_req.addr];
      res_rdata <= res_mem[mem_req.addr];
   end

endmodule

FILE: rtl/core/ogi_sweep.sv
// Inflation sequencer: four line sweeps with one shared distance counter.
// Depends on ogi_pkg; drives the scratch and result stores of ogi_mem.
module ogi_sweep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ogi_pkg::COORD_W-1:0]      wm1,
   input  logic [ogi_pkg::COORD_W-1:0]      hm1,
   input  logic [ogi_pkg::RADIUS_W-1:0]     radius,
   input  logic [7:0]                       raw_rdata,
   input  logic [ogi_pkg::SCR_W-1:0]        scr_rdata,
   output ogi_pkg::mem_req_type             mem_req,
   output logic                             done
);

   typedef enum logic [2:0] {
      SW_IDLE, SW_ROW_FWD, SW_ROW_BWD, SW_COL_FWD, SW_COL_BWD
   } sweep_state_type;

   sweep_state_type                state_ff, state_in;
   logic                           phase_ff, phase_in;
   logic [ogi_pkg::COORD_W-1:0]    inner_ff, inner_in;
   logic [ogi_pkg::COORD_W-1:0]    outer_ff, outer_in;
   logic [ogi_pkg::DIST_W-1:0]     dist_ff, dist_in;
   logic                           done_ff, done_in;

   logic                           row_pass;
   logic                           fwd;
   logic [ogi_pkg::COORD_W-1:0]    inner_max;
   logic [ogi_pkg::COORD_W-1:0]    outer_max;
   logic [ogi_pkg::COORD_W-1:0]    pos;
   logic [ogi_pkg::COORD_W-1:0]    row;
   logic [ogi_pkg::COORD_W-1:0]    col;
   logic                           src;
   logic                           hit;
   logic                           raw_occ;
   logic                           raw_caution;
   logic                           raw_known;
   logic [1:0]                     code;

   assign row_pass  = (state_ff == SW_ROW_FWD) || (state_ff == SW_ROW_BWD);
   assign fwd       = (state_ff == SW_ROW_FWD) || (state_ff == SW_COL_FWD);
   assign inner_max = row_pass ? wm1 : hm1;
   assign outer_max = row_pass ? hm1 : wm1;
   assign pos       = fwd ? inner_ff : inner_max - inner_ff;
   assign row       = row_pass ? outer_ff : pos;
   assign col       = row_pass ? pos : outer_ff;

   assign raw_occ     = $signed(raw_rdata) >= ogi_pkg::OCC_LEVEL;
   assign raw_caution = $signed(raw_rdata) >= ogi_pkg::CAUTION_LEVEL;
   assign raw_known   = !raw_rdata[7];

   always_comb begin
      case (state_ff)
         SW_ROW_FWD: src = raw_occ;
         SW_ROW_BWD: src = scr_rdata[0];
         default:    src = scr_rdata[1];
      endcase
      if (src) begin
         dist_in = '0;
      end else if (inner_ff == '0) begin
         dist_in = ogi_pkg::DIST_SAT;
      end else if (dist_ff == ogi_pkg::DIST_SAT) begin
         dist_in = dist_ff;
      end else begin
         dist_in = dist_ff + 1'b1;
      end
      hit = dist_in <= {1'b0, radius};

      if (raw_occ) begin
         code = ogi_pkg::CODE_OCCUPIED;
      end else if (raw_caution || scr_rdata[2] || hit) begin
         code = ogi_pkg::CODE_CAUTION;
      end else if (raw_known) begin
         code = ogi_pkg::CODE_FREE;
      end else begin
         code = ogi_pkg::CODE_UNKNOWN;
      end

      mem_req           = '0;
      mem_req.addr      = {row, col};
      mem_req.res_wdata = code;
      case (state_ff)
         SW_ROW_FWD: mem_req.scr_wdata = {1'b0, hit, raw_occ};
         SW_ROW_BWD: mem_req.scr_wdata = {scr_rdata[2], scr_rdata[1] | hit, scr_rdata[0]};
         default:    mem_req.scr_wdata = {hit, scr_rdata[1], scr_rdata[0]};
      endcase
      mem_req.scr_we = phase_ff && (state_ff != SW_IDLE) && (state_ff != SW_COL_BWD);
      mem_req.res_we = phase_ff && (state_ff == SW_COL_BWD);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      done_in  = 1'b0;
      case (state_ff)
         SW_IDLE: begin
            if (start) begin
               state_in = SW_ROW_FWD;
               phase_in = 1'b0;
               inner_in = '0;
               outer_in = '0;
            end
         end
         default: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (inner_ff != inner_max) begin
                  inner_in = inner_ff + 1'b1;
               end else begin
                  inner_in = '0;
                  if (outer_ff != outer_max) begin
                     outer_in = outer_ff + 1'b1;
                  end else begin
                     outer_in = '0;
                     case (state_ff)
                        SW_ROW_FWD: state_in = SW_ROW_BWD;
                        SW_ROW_BWD: state_in = SW_COL_FWD;
                        SW_COL_FWD: state_in = SW_COL_BWD;
                        default: begin
                           state_in = SW_IDLE;
                           done_in  = 1'b1;
                        end
                     endcase
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SW_IDLE;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      inner_ff <= inner_in;
      outer_ff <= outer_in;
      if (phase_ff) begin
         dist_ff <= dist_in;
      end
   end

   assign done = done_ff;

endmodule

FILE: rtl/core/occupancy_grid_inflate_unit.sv
// Occupancy grid inflate unit: load, inflate and read back a signed grid.
// Depends on ogi_pkg, ogi_mem and ogi_sweep.
//
// The request channel carries one transaction per command: a load writes one
// raw cell, a run inflates the whole configured grid, a read returns a class.
// Every request transaction gives exactly one response transaction on the
// rsp_ channel with the class (reads only) and a status bit.
// Load: the response is registered at acceptance.
// Read: the class comes from the registered read port of the result store.
// Run: four sweeps over the grid, a read and a write phase per cell
// through the shared distance counter and store port.
// The request side is not ready while a command is in progress or while a
// response waits in the output register, so a stalled receiver holds the
// unit. The csr_ port writes size and radius registers and is always ready;
// write it only while the unit is idle.
// Reset restores width 256, height 256 and radius 6; the grid stores are
// not cleared and must be loaded before use.
module occupancy_grid_inflate_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // op[1:0], row[9:2], col[17:10], raw_value[25:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cell_class[7:0], status[8]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE, ST_READ, ST_RUN
   } top_state_type;

   top_state_type                 state_ff, state_in;
   logic [ogi_pkg::SIZE_W-1:0]    width_ff, height_ff;
   logic [ogi_pkg::RADIUS_W-1:0]  radius_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_class_ff, rsp_class_in;
   logic                          rsp_status_ff, rsp_status_in;

   logic [1:0]                    op;
   logic [7:0]                    row, col, raw_value;
   logic [ogi_pkg::SIZE_W-1:0]    eff_w, eff_h;
   logic [ogi_pkg::SIZE_W-1:0]    wm1_full, hm1_full;
   logic                          in_grid, empty_grid, accept, start;
   logic [7:0]                    raw_rdata;
   logic [ogi_pkg::SCR_W-1:0]     scr_rdata;
   logic [1:0]                    res_rdata;
   logic                          sweep_done;
   ogi_pkg::mem_req_type          host_req, sweep_req, mem_req;

   assign op        = req_tdata[1:0];
   assign row       = req_tdata[9:2];
   assign col       = req_tdata[17:10];
   assign raw_value = req_tdata[25:18];

   assign eff_w      = (width_ff > ogi_pkg::MAX_SIZE) ? ogi_pkg::MAX_SIZE : width_ff;
   assign eff_h      = (height_ff > ogi_pkg::MAX_SIZE) ? ogi_pkg::MAX_SIZE : height_ff;
   assign wm1_full   = eff_w - 1'b1;
   assign hm1_full   = eff_h - 1'b1;
   assign in_grid    = ({1'b0, row} < eff_h) && ({1'b0, col} < eff_w);
   assign empty_grid = (eff_w == '0) || (eff_h == '0);

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (op == ogi_pkg::OP_RUN) && !empty_grid;
   assign csr_ready  = 1'b1;

   always_comb begin
      host_req           = '0;
      host_req.addr      = {row, col};
      host_req.raw_wdata = raw_value;
      host_req.raw_we    = accept && (op == ogi_pkg::OP_LOAD) && in_grid;
      mem_req            = (state_ff == ST_RUN) ? sweep_req : host_req;
   end

   ogi_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .raw_rdata (raw_rdata),
      .scr_rdata (scr_rdata),
      .res_rdata (res_rdata)
   );

   ogi_sweep u_sweep (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .wm1       (wm1_full[ogi_pkg::COORD_W-1:0]),
      .hm1       (hm1_full[ogi_pkg::COORD_W-1:0]),
      .radius    (radius_ff),
      .raw_rdata (raw_rdata),
      .scr_rdata (scr_rdata),
      .mem_req   (sweep_req),
      .done      (sweep_done)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_class_in  = rsp_class_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_class_in = 8'd0;
               if (op == ogi_pkg::OP_READ && in_grid) begin
                  state_in = ST_READ;
               end else if (op == ogi_pkg::OP_RUN && !empty_grid) begin
                  state_in = ST_RUN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = !(op == ogi_pkg::OP_RUN ||
                                    (op == ogi_pkg::OP_LOAD && in_grid));
               end
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_class_in  = ogi_pkg::code_value(res_rdata);
            rsp_status_in = 1'b0;
            state_in      = ST_IDLE;
         end
         ST_RUN: begin
            if (sweep_done) begin
               rsp_valid_in  = 1'b1;
               rsp_class_in  = 8'd0;
               rsp_status_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         radius_ff    <= 4'd6;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               ogi_pkg::CSR_WIDTH:  width_ff  <= csr_data;
               ogi_pkg::CSR_HEIGHT: height_ff <= csr_data;
               ogi_pkg::CSR_RADIUS: radius_ff <= csr_data[ogi_pkg::RADIUS_W-1:0];
               default: ;
            endcase
         end
      end
      rsp_class_ff  <= rsp_class_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_class_ff};

endmodule
